/* rtl/bcm_pkg.sv */
// shared types and constants of the binary cross morphology unit
package bcm_pkg;

    // field widths
    localparam int COLOR_W    = 8;
    localparam int SUM_W      = 10;
    localparam int MODE_W     = 2;
    localparam int DIM_W      = 11;
    localparam int THR_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // output queue geometry
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = 2;
    localparam int OUT_CNT_W  = 3;

    // item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // morphology modes
    localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd3;

    // register reset values
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd800;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd600;
    localparam logic [THR_W-1:0] THRESH_RESET = 10'd382;

    // event offered to a morphology stage
    typedef struct packed {
        logic valid;
        logic has_in;
    } t_stage_ev;

    // result leaving a morphology stage
    typedef struct packed {
        logic valid;
        logic pixel_white;
        logic end_of_frame;
    } t_stage_res;

    // output queue entry
    typedef struct packed {
        logic pixel_white;
        logic end_of_frame;
    } t_out_word;

endpackage

/* rtl/bcm_if.sv */
// handshake channels of the binary cross morphology unit

interface bcm_pix_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [bcm_pkg::COLOR_W-1:0]  red;
    logic [bcm_pkg::COLOR_W-1:0]  green;
    logic [bcm_pkg::COLOR_W-1:0]  blue;

    modport source (output valid, output kind, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input kind, input red, input green, input blue,
                    output ready);
endinterface

interface bcm_res_if;
    logic valid;
    logic ready;
    logic pixel_white;
    logic end_of_frame;

    modport source (output valid, output pixel_white, output end_of_frame, input ready);
    modport sink   (input valid, input pixel_white, input end_of_frame, output ready);
endinterface

interface bcm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bcm_pkg::CFG_IDX_W-1:0]  index;
    logic [bcm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/bcm_stage.sv */
// one 3x3 cross morphology stage around a two-line bit store
module bcm_stage #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_clear,
    input  logic                                  i_dilate,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]      i_width,
    input  logic [$clog2(MAX_HEIGHT + 1)-1:0]     i_height,
    input  bcm_pkg::t_stage_ev                    i_ev,
    input  logic                                  i_bit,
    output bcm_pkg::t_stage_res                   o_res
);

    localparam int AW    = $clog2(MAX_WIDTH) + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int YW    = $clog2(MAX_HEIGHT);

    // word: bit0 own pixel, bit1 pixel one line above
    logic [1:0]    r_store [DEPTH];

    logic [AW-1:0] r_wr, n_wr;
    logic [WW-1:0] r_pend, n_pend;
    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;

    logic [AW-1:0] r_d_wa;
    logic          r_d_emit, r_d_write;
    logic          r_d_up, r_d_left, r_d_right, r_d_down, r_d_eof;
    logic          r_fa, r_fb;
    logic [1:0]    r_qa, r_qb, r_last_wd;
    logic          r_prev_c;

    logic          x_last, y_last, pend_lt_w, emit, wr_en;
    logic [WW-1:0] back;
    logic [AW-1:0] addr_a, addr_b;
    logic          use_up, use_left, use_right, use_down;
    logic [1:0]    a_word, b_word, wdata;
    logic          centre, up, right, res_bit;

    // decision side
    assign x_last    = (WW'(r_x) == i_width - WW'(1));
    assign y_last    = (HW'(r_y) == i_height - HW'(1));
    assign pend_lt_w = (r_pend < i_width);
    assign wr_en     = i_ev.valid && i_ev.has_in;
    assign emit      = i_ev.valid && (i_ev.has_in ? !pend_lt_w : (r_pend != '0));
    assign back      = i_ev.has_in ? i_width : r_pend;
    assign addr_a    = r_wr - AW'(back);
    assign addr_b    = addr_a + AW'(1);

    assign use_up    = (r_y != '0);
    assign use_left  = (r_x != '0);
    assign use_right = !x_last && (i_ev.has_in || (r_pend > WW'(1)));
    assign use_down  = i_ev.has_in && !y_last;

    always_comb begin
        n_wr   = wr_en ? r_wr + AW'(1) : r_wr;
        n_pend = r_pend;
        if (i_ev.valid) begin
            if (i_ev.has_in) begin
                if (pend_lt_w) begin
                    n_pend = r_pend + WW'(1);
                end
            end else if (r_pend != '0) begin
                n_pend = r_pend - WW'(1);
            end
        end
        n_x = r_x;
        n_y = r_y;
        if (emit) begin
            if (x_last) begin
                n_x = '0;
                n_y = y_last ? '0 : r_y + YW'(1);
            end else begin
                n_x = r_x + XW'(1);
            end
        end
    end

    // data side, in the cycle after the decision
    assign a_word = r_fa ? r_last_wd : r_qa;
    assign b_word = r_fb ? r_last_wd : r_qb;
    assign centre = a_word[0];
    assign up     = a_word[1];
    assign right  = b_word[0];
    assign wdata  = {a_word[0], i_bit};

    always_comb begin
        if (i_dilate) begin
            res_bit = centre | (r_d_up & up) | (r_d_left & r_prev_c)
                    | (r_d_right & right) | (r_d_down & i_bit);
        end else begin
            res_bit = centre & (!r_d_up | up) & (!r_d_left | r_prev_c)
                    & (!r_d_right | right) & (!r_d_down | i_bit);
        end
    end

    assign o_res.valid        = r_d_emit;
    assign o_res.pixel_white  = res_bit;
    assign o_res.end_of_frame = r_d_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wr      <= '0;
            r_pend    <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_d_emit  <= 1'b0;
            r_d_write <= 1'b0;
        end else begin
            r_wr      <= n_wr;
            r_pend    <= n_pend;
            r_x       <= n_x;
            r_y       <= n_y;
            r_d_emit  <= emit;
            r_d_write <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_wa    <= r_wr;
        r_d_up    <= use_up;
        r_d_left  <= use_left;
        r_d_right <= use_right;
        r_d_down  <= use_down;
        r_d_eof   <= x_last && y_last;
        // the write of the item in its data cycle lands at this same edge
        r_fa      <= r_d_write && (addr_a == r_d_wa);
        r_fb      <= r_d_write && (addr_b == r_d_wa);
        if (r_d_write) begin
            r_last_wd <= wdata;
        end
        if (r_d_emit) begin
            r_prev_c <= centre;
        end
    end

    // line store, read-first
    always_ff @(posedge i_clk) begin
        if (r_d_write) begin
            r_store[r_d_wa] <= wdata;
        end
        r_qa <= r_store[addr_a];
        r_qb <= r_store[addr_b];
    end

endmodule

/* rtl/binary_cross_morphology_unit.sv */
// top level of the binary cross morphology unit
//
// i_pix takes one beat per raster pixel (kind pixel) or a flush beat (kind
// flush) that pushes out pixels still held in the line stores. each pixel is
// made white when red + green + blue is below white_threshold, then goes
// through one 3x3 cross stage (erode, dilate) or two (open, close).
// o_res gives the result pixel and an end-of-frame flag on the last pixel.
// i_cfg writes mode, frame_width, frame_height and white_threshold; writing
// any of the first three empties the pipeline. write only while idle.
// throughput is one beat per cycle on i_pix and o_res while o_res.ready is
// high and the queue has room. each stage holds back frame_width pixels before
// its first result; beyond that a result goes from its causing beat through the
// decision cycle, the line store read, the cascade stage, then the output queue.
// a four-entry output queue decouples the sides: i_pix.ready drops when the
// queue plus beats in flight could overflow it, so a stalled receiver only
// holds off new input and nothing is lost.
// reset (synchronous, active low) restores the register defaults and empties
// the pipeline and queue; the line stores hold no reset state.
module binary_cross_morphology_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bcm_pix_if.sink   i_pix,
    bcm_res_if.source o_res,
    bcm_cfg_if.sink   i_cfg
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // configuration registers
    logic [bcm_pkg::MODE_W-1:0] r_mode;
    logic [bcm_pkg::DIM_W-1:0]  r_frame_width;
    logic [bcm_pkg::DIM_W-1:0]  r_frame_height;
    logic [bcm_pkg::THR_W-1:0]  r_white_threshold;

    logic cfg_fire, cfg_clear;

    // geometry in use, clamped to the store size
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    // binarize
    logic [bcm_pkg::SUM_W-1:0] sum;
    logic                      pix_bit;
    logic                      accept;

    // mode decode
    logic two_stage, dilate_1, dilate_2;

    // pipeline between the stages
    logic r_s1_valid, r_s1_flush, r_s1_bit;
    logic r_s2_valid, r_s2_hit, r_s2_bit, r_s2_eof;

    bcm_pkg::t_stage_ev  ev_1, ev_2;
    bcm_pkg::t_stage_res res_1, res_2;

    // output queue
    bcm_pkg::t_out_word             r_fifo [bcm_pkg::OUT_DEPTH];
    logic [bcm_pkg::OUT_PTR_W-1:0]  r_wp, r_rp;
    logic [bcm_pkg::OUT_CNT_W-1:0]  r_cnt, occupancy;
    logic                           push, pop;
    bcm_pkg::t_out_word             push_word;

    // config port always takes a beat
    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign cfg_clear   = cfg_fire && ((i_cfg.index == bcm_pkg::CFG_MODE)
                                   || (i_cfg.index == bcm_pkg::CFG_WIDTH)
                                   || (i_cfg.index == bcm_pkg::CFG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= bcm_pkg::MODE_ERODE;
            r_frame_width     <= bcm_pkg::WIDTH_RESET;
            r_frame_height    <= bcm_pkg::HEIGHT_RESET;
            r_white_threshold <= bcm_pkg::THRESH_RESET;
        end else if (cfg_fire) begin
            case (i_cfg.index)
                bcm_pkg::CFG_MODE: begin
                    r_mode <= i_cfg.data[bcm_pkg::MODE_W-1:0];
                end
                bcm_pkg::CFG_WIDTH: begin
                    r_frame_width <= i_cfg.data;
                end
                bcm_pkg::CFG_HEIGHT: begin
                    r_frame_height <= i_cfg.data;
                end
                bcm_pkg::CFG_THRESH: begin
                    r_white_threshold <= i_cfg.data[bcm_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // zero reads as one, oversize saturates
    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_frame_height);
        end
    end

    assign two_stage = (r_mode == bcm_pkg::MODE_OPEN) || (r_mode == bcm_pkg::MODE_CLOSE);
    assign dilate_1  = (r_mode == bcm_pkg::MODE_DILATE) || (r_mode == bcm_pkg::MODE_CLOSE);
    assign dilate_2  = (r_mode == bcm_pkg::MODE_OPEN);

    // threshold above the largest sum makes every pixel white by itself
    assign sum     = bcm_pkg::SUM_W'(i_pix.red) + bcm_pkg::SUM_W'(i_pix.green)
                   + bcm_pkg::SUM_W'(i_pix.blue);
    assign pix_bit = (sum < r_white_threshold);

    assign accept      = i_pix.valid && i_pix.ready;
    assign ev_1.valid  = accept;
    assign ev_1.has_in = (i_pix.kind == bcm_pkg::KIND_PIXEL);

    bcm_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_stage_1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_clear),
        .i_dilate (dilate_1),
        .i_width  (eff_w),
        .i_height (eff_h),
        .i_ev     (ev_1),
        .i_bit    (r_s1_bit),
        .o_res    (res_1)
    );

    // second stage sees the first stage's result, or the flush when the
    // first stage had nothing left
    assign ev_2.valid  = two_stage && r_s1_valid && (res_1.valid || r_s1_flush);
    assign ev_2.has_in = res_1.valid;

    bcm_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_stage_2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_clear),
        .i_dilate (dilate_2),
        .i_width  (eff_w),
        .i_height (eff_h),
        .i_ev     (ev_2),
        .i_bit    (r_s2_bit),
        .o_res    (res_2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_hit   <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s2_hit   <= r_s1_valid && res_1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_flush <= (i_pix.kind == bcm_pkg::KIND_FLUSH);
        r_s1_bit   <= pix_bit;
        // doubles as second stage input and single stage result
        r_s2_bit   <= res_1.pixel_white;
        r_s2_eof   <= res_1.end_of_frame;
    end

    // result of the item in its last pipeline cycle
    assign push = r_s2_valid && (two_stage ? res_2.valid : r_s2_hit);
    assign push_word.pixel_white  = two_stage ? res_2.pixel_white : r_s2_bit;
    assign push_word.end_of_frame = two_stage ? res_2.end_of_frame : r_s2_eof;

    assign pop = o_res.valid && o_res.ready;

    // room for everything already in flight
    assign occupancy   = r_cnt + bcm_pkg::OUT_CNT_W'(r_s1_valid)
                       + bcm_pkg::OUT_CNT_W'(r_s2_valid);
    assign i_pix.ready = (occupancy < bcm_pkg::OUT_CNT_W'(bcm_pkg::OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + bcm_pkg::OUT_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + bcm_pkg::OUT_PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + bcm_pkg::OUT_CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - bcm_pkg::OUT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= push_word;
        end
    end

    assign o_res.valid        = (r_cnt != '0);
    assign o_res.pixel_white  = r_fifo[r_rp].pixel_white;
    assign o_res.end_of_frame = r_fifo[r_rp].end_of_frame;

endmodule

/* test/tb_top.sv */
// self-checking testbench for binary_cross_morphology_unit with a scoreboard class
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam int STORE_DEPTH  = 2 * MAX_W;
    localparam int TARGET_BEATS = 750;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_PIXELS  = 40;
    localparam int SETTLE_WAIT  = 8;
    localparam int CYCLE_LIMIT  = 400000;

    // tracks the block: binarize, one or two cross stages, queue of expected pixels
    class morph_scoreboard;
        logic [bcm_pkg::MODE_W-1:0] mode_reg;
        logic [bcm_pkg::DIM_W-1:0]  width_reg;
        logic [bcm_pkg::DIM_W-1:0]  height_reg;
        logic [bcm_pkg::THR_W-1:0]  thresh_reg;
        bit                         line_store[2][STORE_DEPTH];
        int unsigned                wr_ptr[2];
        int unsigned                held[2];
        int unsigned                out_pos[2];
        bcm_pkg::t_out_word         expected_pixels[$];
        int unsigned                errors;

        function new();
            mode_reg   = bcm_pkg::MODE_ERODE;
            width_reg  = bcm_pkg::WIDTH_RESET;
            height_reg = bcm_pkg::HEIGHT_RESET;
            thresh_reg = bcm_pkg::THRESH_RESET;
            errors     = 0;
            flush_state();
        endfunction

        function void flush_state();
            for (int s = 0; s < 2; s++) begin
                wr_ptr[s]  = 0;
                held[s]    = 0;
                out_pos[s] = 0;
            end
        endfunction

        function int unsigned cols();
            if (width_reg == '0) return 1;
            if (32'(width_reg) > MAX_W) return MAX_W;
            return 32'(width_reg);
        endfunction

        function int unsigned rows();
            if (height_reg == '0) return 1;
            if (32'(height_reg) > MAX_H) return MAX_H;
            return 32'(height_reg);
        endfunction

        function int unsigned slot_back(int unsigned p, int unsigned k);
            return (p + STORE_DEPTH - k) % STORE_DEPTH;
        endfunction

        function bit merge(bit grow, bit a, bit b);
            return grow ? (a | b) : (a & b);
        endfunction

        // one cross stage; returns 1 when a pixel leaves it
        function bit cross_stage(int s, bit grow, bit has_in, bit px,
                                 output bit px_out, output bit eof_out);
            int unsigned w, h, avail, back, x, y;
            bit acc;
            w = cols();
            h = rows();
            px_out = 1'b0;
            eof_out = 1'b0;
            if (has_in) begin
                if (held[s] < w) begin
                    line_store[s][wr_ptr[s]] = px;
                    wr_ptr[s] = (wr_ptr[s] + 1) % STORE_DEPTH;
                    held[s]++;
                    return 1'b0;
                end
                avail = w + 1;
                back = w;
            end else begin
                if (held[s] == 0) return 1'b0;
                avail = held[s];
                back = held[s];
            end
            x = out_pos[s] % w;
            y = out_pos[s] / w;
            acc = line_store[s][slot_back(wr_ptr[s], back)];
            if (y > 0)
                acc = merge(grow, acc, line_store[s][slot_back(wr_ptr[s], back + w)]);
            if (x > 0)
                acc = merge(grow, acc, line_store[s][slot_back(wr_ptr[s], back + 1)]);
            if (x + 1 < w && avail > 1)
                acc = merge(grow, acc, line_store[s][slot_back(wr_ptr[s], back - 1)]);
            if (y + 1 < h && avail > w)
                acc = merge(grow, acc, px);
            if (has_in) begin
                line_store[s][wr_ptr[s]] = px;
                wr_ptr[s] = (wr_ptr[s] + 1) % STORE_DEPTH;
            end else begin
                held[s]--;
            end
            eof_out = (out_pos[s] + 1 >= w * h);
            out_pos[s] = eof_out ? 0 : out_pos[s] + 1;
            px_out = acc;
            return 1'b1;
        endfunction

        function void write_reg(logic [bcm_pkg::CFG_IDX_W-1:0] idx,
                                logic [bcm_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                bcm_pkg::CFG_MODE: begin
                    mode_reg = val[bcm_pkg::MODE_W-1:0];
                    flush_state();
                end
                bcm_pkg::CFG_WIDTH: begin
                    width_reg = val[bcm_pkg::DIM_W-1:0];
                    flush_state();
                end
                bcm_pkg::CFG_HEIGHT: begin
                    height_reg = val[bcm_pkg::DIM_W-1:0];
                    flush_state();
                end
                bcm_pkg::CFG_THRESH: thresh_reg = val[bcm_pkg::THR_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_beat(logic kind, logic [bcm_pkg::COLOR_W-1:0] r,
                                logic [bcm_pkg::COLOR_W-1:0] g,
                                logic [bcm_pkg::COLOR_W-1:0] b);
            int unsigned sum;
            bit px, is_pixel, first_grow, two_stage, b1, e1, b2, e2, got1, got2;
            bcm_pkg::t_out_word word;
            sum = 32'(r);
            sum += 32'(g);
            sum += 32'(b);
            px = (sum < 32'(thresh_reg));
            is_pixel = (kind == bcm_pkg::KIND_PIXEL);
            first_grow = (mode_reg == bcm_pkg::MODE_DILATE)
                      || (mode_reg == bcm_pkg::MODE_CLOSE);
            two_stage = (mode_reg == bcm_pkg::MODE_OPEN) || (mode_reg == bcm_pkg::MODE_CLOSE);
            got1 = cross_stage(0, first_grow, is_pixel, px, b1, e1);
            if (!two_stage) begin
                if (got1) begin
                    word.pixel_white = b1;
                    word.end_of_frame = e1;
                    expected_pixels.push_back(word);
                end
                return;
            end
            got2 = 1'b0;
            if (got1)
                got2 = cross_stage(1, mode_reg == bcm_pkg::MODE_OPEN, 1'b1, b1, b2, e2);
            else if (!is_pixel)
                got2 = cross_stage(1, mode_reg == bcm_pkg::MODE_OPEN, 1'b0, 1'b0, b2, e2);
            if (got2) begin
                word.pixel_white = b2;
                word.end_of_frame = e2;
                expected_pixels.push_back(word);
            end
        endfunction

        function void match_result(logic white, logic eof);
            bcm_pkg::t_out_word want;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: stray result, expected none, got white %0b eof %0b",
                         $time, white, eof);
                return;
            end
            want = expected_pixels.pop_front();
            if (white !== want.pixel_white) begin
                errors++;
                $display("%0t: pixel_white mismatch, expected %0b, got %0b",
                         $time, want.pixel_white, white);
            end
            if (eof !== want.end_of_frame) begin
                errors++;
                $display("%0t: end_of_frame mismatch, expected %0b, got %0b",
                         $time, want.end_of_frame, eof);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bcm_pix_if pix ();
    bcm_res_if res ();
    bcm_cfg_if cfg ();

    binary_cross_morphology_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    morph_scoreboard sb;

    // idling switches, changed per phase by the stimulus
    bit send_bursty = 1'b1;
    bit recv_bursty = 1'b1;
    // asks the result side for one long hold-off
    bit hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    // all beats are sampled at the rising edge; results are checked before new
    // inputs are noted so a stray result cannot be masked by a fresh expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res.valid && res.ready)
                sb.match_result(res.pixel_white, res.end_of_frame);
            if (pix.valid && pix.ready)
                sb.take_beat(pix.kind, pix.red, pix.green, pix.blue);
            if (cfg.valid && cfg.ready)
                sb.write_reg(cfg.index, cfg.data);
        end
    end

    // result side: random stall before each beat, plus one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        res.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = recv_bursty ? $urandom_range(0, 8) : 0;
            if (stall != 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!res.valid && !hold_req);
        end
    end

    // hang guard
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // offer one beat on i_pix after a random gap; valid stays high afterwards
    task automatic drive_beat(input logic kind, input logic [bcm_pkg::COLOR_W-1:0] r,
                              input logic [bcm_pkg::COLOR_W-1:0] g,
                              input logic [bcm_pkg::COLOR_W-1:0] b);
        int unsigned gap;
        gap = send_bursty ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.kind  <= kind;
        pix.red   <= r;
        pix.green <= g;
        pix.blue  <= b;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    task automatic drive_flush();
        drive_beat(bcm_pkg::KIND_FLUSH, bcm_pkg::COLOR_W'($urandom_range(0, 255)),
                   bcm_pkg::COLOR_W'($urandom_range(0, 255)),
                   bcm_pkg::COLOR_W'($urandom_range(0, 255)));
    endtask

    // one register write, then valid drops so writes never touch back to back
    task automatic write_cfg(input logic [bcm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bcm_pkg::CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, wait for every expected pixel, then give the pipe time to go quiet
    task automatic settle();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [bcm_pkg::CFG_DATA_W-1:0] pick_width();
        case ($urandom_range(0, 15))
            0: return 11'd0;
            1: return 11'd1024;
            2: return 11'd2047;
            3: return bcm_pkg::CFG_DATA_W'($urandom_range(1025, 2046));
            default: return bcm_pkg::CFG_DATA_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [bcm_pkg::CFG_DATA_W-1:0] pick_height();
        case ($urandom_range(0, 15))
            0: return 11'd0;
            1: return 11'd1024;
            2: return 11'd2047;
            default: return bcm_pkg::CFG_DATA_W'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [bcm_pkg::CFG_DATA_W-1:0] pick_thresh();
        case ($urandom_range(0, 7))
            0: return 11'd0;
            1: return 11'd766;
            2: return 11'd767;
            3: return 11'd1023;
            4: return bcm_pkg::CFG_DATA_W'($urandom_range(0, 2047));
            default: return bcm_pkg::CFG_DATA_W'($urandom_range(300, 460));
        endcase
    endfunction

    initial begin : stimulus
        int unsigned beats, since_clear, w, h, npix, nflush, phase;
        bit held_off, hold_phase;
        sb = new();
        beats = 0;
        since_clear = 0;
        held_off = 1'b0;
        pix.valid <= 1'b0;
        pix.kind  <= bcm_pkg::KIND_PIXEL;
        pix.red   <= '0;
        pix.green <= '0;
        pix.blue  <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= bcm_pkg::CFG_MODE;
        cfg.data  <= '0;
        i_rst_n   <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings (erode, 800 wide, threshold 382), color extremes
        // and both sides of the threshold; the line never fills so flushes drain it,
        // the last flush finds nothing pending
        drive_beat(bcm_pkg::KIND_PIXEL, 8'd0, 8'd0, 8'd0);
        drive_beat(bcm_pkg::KIND_PIXEL, 8'd255, 8'd255, 8'd255);
        drive_beat(bcm_pkg::KIND_PIXEL, 8'd127, 8'd127, 8'd127);
        drive_beat(bcm_pkg::KIND_PIXEL, 8'd128, 8'd127, 8'd127);
        drive_beat(bcm_pkg::KIND_PIXEL, 8'd255, 8'd0, 8'd0);
        repeat (6) drive_flush();
        settle();

        // directed: two-stage open on a 2x2 frame with a threshold above the
        // largest sum, so every pixel is white; flushes reach the second stage
        write_cfg(bcm_pkg::CFG_MODE, bcm_pkg::CFG_DATA_W'(bcm_pkg::MODE_OPEN));
        write_cfg(bcm_pkg::CFG_WIDTH, 11'd2);
        write_cfg(bcm_pkg::CFG_HEIGHT, 11'd2);
        write_cfg(bcm_pkg::CFG_THRESH, 11'd767);
        drive_beat(bcm_pkg::KIND_PIXEL, 8'd255, 8'd255, 8'd255);
        drive_beat(bcm_pkg::KIND_PIXEL, 8'd0, 8'd0, 8'd0);
        drive_beat(bcm_pkg::KIND_PIXEL, 8'd255, 8'd255, 8'd254);
        drive_beat(bcm_pkg::KIND_PIXEL, 8'd17, 8'd200, 8'd90);
        repeat (6) drive_flush();

        // random phases: back-to-back frames with random content, stray flushes,
        // and mostly a full drain at the end
        phase = 0;
        while (beats < TARGET_BEATS) begin
            settle();
            // once, on a narrow frame, stall the result side for a long stretch while
            // pixels keep coming back to back, so the output queue fills and input backs up
            hold_phase = !held_off && (beats > 300);
            // geometry writes clear the pipe; threshold-only phases keep it running
            if (phase == 0 || hold_phase || $urandom_range(0, 3) != 0) begin
                write_cfg(bcm_pkg::CFG_MODE, bcm_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
                write_cfg(bcm_pkg::CFG_WIDTH, hold_phase
                          ? bcm_pkg::CFG_DATA_W'($urandom_range(1, 6)) : pick_width());
                write_cfg(bcm_pkg::CFG_HEIGHT, pick_height());
                since_clear = 0;
            end
            write_cfg(bcm_pkg::CFG_THRESH, pick_thresh());
            send_bursty = ($urandom_range(0, 3) != 0);
            recv_bursty = ($urandom_range(0, 3) != 0);
            if (hold_phase) begin
                held_off = 1'b1;
                send_bursty = 1'b0;
                hold_req = 1'b1;
            end
            w = sb.cols();
            h = sb.rows();
            // wide lines would need a thousand pixels each: keep those short
            // and let flushes push them out
            if (w > 64) begin
                npix = $urandom_range(5, 30);
            end else begin
                npix = $urandom_range(1, 3) * w * h + $urandom_range(0, w);
                if (npix > 120) npix = $urandom_range(60, 120);
            end
            if (hold_phase && npix < HOLD_PIXELS) npix = HOLD_PIXELS;
            for (int i = 0; i < npix; i++) begin
                if ($urandom_range(0, 15) == 0) begin
                    drive_flush();
                    beats++;
                end
                drive_beat(bcm_pkg::KIND_PIXEL, bcm_pkg::COLOR_W'($urandom_range(0, 255)),
                           bcm_pkg::COLOR_W'($urandom_range(0, 255)),
                           bcm_pkg::COLOR_W'($urandom_range(0, 255)));
                beats++;
                since_clear++;
            end
            // each stage holds at most one line, so this many flushes empties both
            if ($urandom_range(0, 3) != 0) begin
                nflush = 2 * ((since_clear < w) ? since_clear : w) + 2;
                repeat (nflush) drive_flush();
                beats += nflush;
            end
            phase++;
        end

        settle();
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/bcm_pkg.sv
rtl/bcm_if.sv
rtl/bcm_stage.sv
rtl/binary_cross_morphology_unit.sv
test/tb_top.sv
